// File: hdl/bcdd_pkg.sv
package bcdd_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int COL_W  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

  localparam int DEPTH_W = 16;
  localparam int DIFF_W  = 18;
  localparam int PROD_W  = DEPTH_W + 1 + DIFF_W;
  localparam int MAG_W   = 32;
  localparam int POS_W   = 32;
  localparam int CNT_W   = $clog2(MAG_W);

  localparam logic [1:0] CFG_FOCAL_X  = 2'd0;
  localparam logic [1:0] CFG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] CFG_CENTER_X = 2'd2;
  localparam logic [1:0] CFG_CENTER_Y = 2'd3;

  localparam logic [15:0] FOCAL_X_RESET  = 16'd7394;
  localparam logic [15:0] FOCAL_Y_RESET  = 16'd7394;
  localparam logic [15:0] CENTER_X_RESET = 16'd5120;
  localparam logic [15:0] CENTER_Y_RESET = 16'd3840;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BOX   = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_START,
    S_WAIT,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic in_stall;
    logic pix_write;
    logic box_take;
    logic mem_read;
    logic prod_load;
    logic div_start;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

// File: hdl/box_center_depth_deprojection.sv
// Box center depth deprojection.
// Input channel (in_valid / in_stall) carries two kinds of request. A pixel
// request (kind 0) writes one depth value into the 640 x 480 frame store and
// gives no result; one is taken every cycle while the block is idle. A box
// request (kind 1) gives exactly one result on the output channel
// (out_valid / out_stall): status, class, and x, y, z position in mm.
// A box request keeps in_stall high until its result is in the output
// register: the controller steps through S_READ, S_CHECK, S_START and S_WAIT,
// where the 32-step bit-serial dividers (one per axis) run, to S_LOAD when
// the center depth is valid, and through S_READ and S_CHECK to S_LOAD when the
// center is outside the frame or the depth is zero.
// The output register holds a result until out_stall is low; a further box
// request is taken but holds in_stall high until that result leaves.
// Configuration (cfg_write / cfg_index / cfg_data) sets focal lengths and
// principal point in 1/16 pixel; write only while the block is idle.
// Synchronous reset restores the register defaults and empties the output;
// the frame store is not cleared and must be written before it is read.
module box_center_depth_deprojection
  import bcdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [9:0]         pixel_col,
  input  logic [8:0]         pixel_row,
  input  logic [15:0]        pixel_depth,
  input  logic signed [15:0] box_xmin,
  input  logic signed [15:0] box_xmax,
  input  logic signed [15:0] box_ymin,
  input  logic signed [15:0] box_ymax,
  input  logic [7:0]         class_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [7:0]         object_class,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        pos_z
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  bcdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  bcdd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .pixel_depth  (pixel_depth),
    .box_xmin     (box_xmin),
    .box_xmax     (box_xmax),
    .box_ymin     (box_ymin),
    .box_ymax     (box_ymax),
    .class_id     (class_id),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .status       (status),
    .object_class (object_class),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z)
  );

  assign in_stall = cmd.in_stall;

endmodule

// File: hdl/bcdd_frame_mem.sv
module bcdd_frame_mem
  import bcdd_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [DEPTH_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [DEPTH_W-1:0] rdata
);

  logic [DEPTH_W-1:0] mem [FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/bcdd_div.sv
module bcdd_div
  import bcdd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [MAG_W-1:0]        num,
  input  logic                    neg,
  input  logic [15:0]             den,
  output logic                    busy,
  output logic signed [POS_W-1:0] result
);

  logic [15:0]      rem;
  logic [MAG_W-1:0] quo;
  logic [15:0]      den_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt;

  logic [16:0] shifted;
  logic [17:0] trial;
  logic        fits;

  assign shifted = {rem, quo[MAG_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};
  assign fits    = ~trial[17];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(MAG_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= (den == 16'd0) ? 16'd1 : den;
      neg_q <= neg;
    end else if (busy) begin
      rem <= fits ? trial[15:0] : shifted[15:0];
      quo <= {quo[MAG_W-2:0], fits};
    end
  end

  always_comb begin
    if (neg_q) begin
      if (quo > {1'b1, {(MAG_W-1){1'b0}}}) begin
        result = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        result = -$signed(quo);
      end
    end else begin
      if (quo[MAG_W-1]) begin
        result = {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        result = $signed(quo);
      end
    end
  end

endmodule

// File: hdl/bcdd_ctrl.sv
module bcdd_ctrl
  import bcdd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       kind,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && kind == KIND_BOX) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_CHECK;
      S_CHECK: state_next = stat.skip ? S_LOAD : S_START;
      S_START: state_next = S_WAIT;
      S_WAIT: begin
        if (!stat.div_busy) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        cmd.in_stall  = 1'b0;
        cmd.pix_write = in_valid && kind == KIND_PIXEL;
        cmd.box_take  = in_valid && kind == KIND_BOX;
      end
      S_READ:  cmd.mem_read  = 1'b1;
      S_CHECK: cmd.prod_load = 1'b1;
      S_START: cmd.div_start = 1'b1;
      S_WAIT:  cmd.out_load  = 1'b0;
      S_LOAD:  cmd.out_load  = stat.out_free;
      default: cmd.in_stall  = 1'b1;
    endcase
  end

endmodule

// File: hdl/bcdd_datapath.sv
module bcdd_datapath
  import bcdd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic [9:0]              pixel_col,
  input  logic [8:0]              pixel_row,
  input  logic [15:0]             pixel_depth,
  input  logic signed [15:0]      box_xmin,
  input  logic signed [15:0]      box_xmax,
  input  logic signed [15:0]      box_ymin,
  input  logic signed [15:0]      box_ymax,
  input  logic [7:0]              class_id,
  input  logic                    out_stall,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              stat,
  output logic                    out_valid,
  output logic [1:0]              status,
  output logic [7:0]              object_class,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic [15:0]             pos_z
);

  logic [15:0] focal_x;
  logic [15:0] focal_y;
  logic [15:0] center_x;
  logic [15:0] center_y;

  logic [7:0]       class_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             outside_q;

  logic signed [16:0] sum_x;
  logic signed [16:0] sum_y;
  logic signed [16:0] half_x;
  logic signed [16:0] half_y;
  logic               outside;

  logic              pix_inside;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       rdata;

  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic [15:0]              depth_q;
  logic [PROD_W-1:0]        abs_x;
  logic [PROD_W-1:0]        abs_y;

  logic                    busy_x;
  logic                    busy_y;
  logic signed [POS_W-1:0] res_x;
  logic signed [POS_W-1:0] res_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= FOCAL_X_RESET;
      focal_y  <= FOCAL_Y_RESET;
      center_x <= CENTER_X_RESET;
      center_y <= CENTER_Y_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FOCAL_X:  focal_x  <= cfg_data;
        CFG_FOCAL_Y:  focal_y  <= cfg_data;
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        default:      focal_x  <= focal_x;
      endcase
    end
  end

  assign sum_x  = 17'(box_xmin) + 17'(box_xmax);
  assign sum_y  = 17'(box_ymin) + 17'(box_ymax);
  assign half_x = (sum_x + $signed({16'd0, sum_x[16]})) >>> 1;
  assign half_y = (sum_y + $signed({16'd0, sum_y[16]})) >>> 1;
  assign outside = half_x[16] || half_y[16]
                || ($unsigned(half_x[15:0]) >= 16'(FRAME_WIDTH))
                || ($unsigned(half_y[15:0]) >= 16'(FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (cmd.box_take) begin
      class_q   <= class_id;
      col_q     <= half_x[COL_W-1:0];
      row_q     <= half_y[ROW_W-1:0];
      outside_q <= outside;
    end
  end

  assign pix_inside = (pixel_col < 10'(FRAME_WIDTH)) && (pixel_row < 9'(FRAME_HEIGHT));
  assign waddr = ADDR_W'(ADDR_W'(pixel_row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(pixel_col));
  assign raddr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(col_q));

  bcdd_frame_mem u_mem (
    .clk   (clk),
    .we    (cmd.pix_write && pix_inside),
    .waddr (waddr),
    .wdata (pixel_depth),
    .re    (cmd.mem_read && !outside_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign diff_x = $signed({2'b00, 16'({col_q, 4'b0000})}) - $signed({2'b00, center_x});
  assign diff_y = $signed({2'b00, 16'({row_q, 4'b0000})}) - $signed({2'b00, center_y});

  always_ff @(posedge clk) begin
    if (cmd.prod_load) begin
      depth_q <= rdata;
      prod_x  <= $signed({1'b0, rdata}) * diff_x;
      prod_y  <= $signed({1'b0, rdata}) * diff_y;
    end
  end

  assign abs_x = prod_x[PROD_W-1] ? PROD_W'(-prod_x) : PROD_W'(prod_x);
  assign abs_y = prod_y[PROD_W-1] ? PROD_W'(-prod_y) : PROD_W'(prod_y);

  bcdd_div u_div_x (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num    (abs_x[MAG_W-1:0]),
    .neg    (prod_x[PROD_W-1]),
    .den    (focal_x),
    .busy   (busy_x),
    .result (res_x)
  );

  bcdd_div u_div_y (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num    (abs_y[MAG_W-1:0]),
    .neg    (prod_y[PROD_W-1]),
    .den    (focal_y),
    .busy   (busy_y),
    .result (res_y)
  );

  assign stat.skip     = outside_q || (rdata == 16'd0);
  assign stat.div_busy = busy_x || busy_y;
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      object_class <= class_q;
      if (outside_q) begin
        status <= STATUS_OUTSIDE;
        pos_x  <= '0;
        pos_y  <= '0;
        pos_z  <= '0;
      end else if (depth_q == 16'd0) begin
        status <= STATUS_MISSING;
        pos_x  <= '0;
        pos_y  <= '0;
        pos_z  <= '0;
      end else begin
        status <= STATUS_OK;
        pos_x  <= res_x;
        pos_y  <= res_y;
        pos_z  <= depth_q;
      end
    end
  end

endmodule
